FILE: rtl/bfa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the frame allocator.
package bfa_pkg;

	localparam int MAX_FRAMES_DEF = 4096;
	localparam int WORD_BITS_DEF  = 64;

	localparam int ACT_W = 2;
	localparam int FI_W  = 12;
	localparam int LEN_W = 13;
	localparam int FP_W  = 13;
	localparam int ST_W  = 2;

	localparam logic [FP_W-1:0] FRAMES_RESET = 13'd4096;

	localparam logic [ACT_W-1:0] ACT_ALLOC      = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE_ONE   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FREE_RANGE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_MARK_ALL   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK           = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_SPACE     = 2'd1;
	localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd2;
	localparam logic [ST_W-1:0] ST_COUNT_ZERO   = 2'd3;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic upd_start;
		logic upd_step;
		logic mark_all;
		logic out_load;
	} bfa_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             len_zero;
		logic             chk_out;
		logic             upd_empty;
		logic             hit;
		logic             exhaust;
		logic             upd_done;
		logic             out_busy;
	} bfa_sts_t;

endpackage

FILE: rtl/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/bfa_ctrl.sv
// Controller state machine sequencing scan, update and result hand-off.
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bfa_pkg::bfa_sts_t sts,
	output bfa_pkg::bfa_cmd_t cmd
);
	import bfa_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DISPATCH  = 3'd1;
	localparam logic [2:0] S_SCAN      = 3'd2;
	localparam logic [2:0] S_UPD_START = 3'd3;
	localparam logic [2:0] S_UPD       = 3'd4;
	localparam logic [2:0] S_DONE      = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.act)
					ACT_ALLOC: begin
						if (sts.len_zero) begin
							state_d = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					ACT_FREE_ONE: begin
						if (sts.chk_out) begin
							state_d = S_DONE;
						end else begin
							cmd.upd_start = 1'b1;
							state_d       = S_UPD;
						end
					end
					ACT_FREE_RANGE: begin
						if (sts.upd_empty) begin
							state_d = S_DONE;
						end else begin
							cmd.upd_start = 1'b1;
							state_d       = S_UPD;
						end
					end
					default: begin
						cmd.mark_all = 1'b1;
						state_d      = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.hit) begin
					state_d = S_UPD_START;
				end else if (sts.exhaust) begin
					state_d = S_DONE;
				end
			end
			S_UPD_START: begin
				cmd.upd_start = 1'b1;
				state_d       = S_UPD;
			end
			S_UPD: begin
				cmd.upd_step = 1'b1;
				if (sts.upd_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/bfa_datapath.sv
// Datapath: bitmap memory, word scan for free runs, masked word updates, result register.
module bfa_datapath #(
	parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
	parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bfa_pkg::FP_W-1:0]  cfg_wdata,
	input  logic [bfa_pkg::ACT_W-1:0] action,
	input  logic [bfa_pkg::FI_W-1:0]  frame_index,
	input  logic [bfa_pkg::LEN_W-1:0] run_length,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bfa_pkg::FI_W-1:0]  frame_index_out,
	output logic [bfa_pkg::ST_W-1:0]  status,
	input  bfa_pkg::bfa_cmd_t         cmd,
	output bfa_pkg::bfa_sts_t         sts
);
	import bfa_pkg::*;

	// WORD_BITS is a power of two
	localparam int WC  = MAX_FRAMES / WORD_BITS;
	localparam int AW  = (WC > 1) ? $clog2(WC) : 1;
	localparam int WBL = $clog2(WORD_BITS);
	localparam int FW  = ($clog2(MAX_FRAMES) + 1 > 14) ? $clog2(MAX_FRAMES) + 1 : 14;
	localparam logic [AW-1:0] LAST = AW'(WC - 1);

	logic [FP_W-1:0]      frames_present_q;
	logic [WC-1:0]        vld_q;
	logic                 rd_pend_q;
	logic                 issued_all_q;
	logic                 out_valid_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        pw_q;
	logic [AW-1:0]        end_q;
	logic                 vld_s1;
	logic [FW-1:0]        carry_q;
	logic [FW-1:0]        lo_q;
	logic [FW-1:0]        hi_q;
	logic [FW-1:0]        len_q;
	logic [ACT_W-1:0]     act_q;
	logic                 len_zero_q;
	logic                 chk_out_q;
	logic [ST_W-1:0]      status_q;
	logic [FI_W-1:0]      frame_q;
	logic [FI_W-1:0]      out_frame_q;
	logic [ST_W-1:0]      out_status_q;

	logic [FW-1:0]        limit_c;
	logic [FW-1:0]        first_c;
	logic [FW-1:0]        sum_c;
	logic [FW-1:0]        fp_c;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] word_c;
	logic [FW-1:0]        base_c;
	logic [WORD_BITS-1:0] free_c;
	logic [FW-1:0]        run_c [WORD_BITS];
	logic                 hit_c;
	logic [FW-1:0]        hi_hit_c;
	logic [FW-1:0]        start_c;
	logic [WORD_BITS-1:0] mask_c;
	logic [WORD_BITS-1:0] wdata_c;
	logic                 bit_c;
	logic                 we_c;
	logic                 issue_c;
	logic [FW-1:0]        lo_sh_c;
	logic [FW-1:0]        hi_sh_c;
	logic [AW-1:0]        lo_word_c;
	logic [AW-1:0]        hi_word_c;

	// frame limit and input frame arithmetic
	always_comb begin
		fp_c    = FW'(frames_present_q);
		limit_c = (fp_c > FW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : fp_c;
		first_c = FW'(frame_index);
		sum_c   = first_c + FW'(run_length);
	end

	// word currently read back; words never written read as all taken
	assign word_c = vld_s1 ? rdata : '1;
	assign base_c = FW'(pw_q) << WBL;

	// free bits inside the frame limit
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			free_c[i] = !word_c[i] && ((base_c + FW'(i)) < limit_c);
		end
	end

	// run of free frames ending at each bit, continuing the carry from earlier words
	always_comb begin
		int  p;
		logic has;
		for (int i = 0; i < WORD_BITS; i++) begin
			p   = 0;
			has = 1'b0;
			for (int j = 0; j < WORD_BITS; j++) begin
				if (j <= i && !free_c[j]) begin
					p   = j;
					has = 1'b1;
				end
			end
			run_c[i] = has ? FW'(i - p) : carry_q + FW'(i + 1);
		end
	end

	// lowest bit where the run reaches the requested length
	always_comb begin
		int idx;
		idx   = 0;
		hit_c = 1'b0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_c[i] && run_c[i] >= len_q) begin
				hit_c = 1'b1;
				idx   = i;
			end
		end
		hi_hit_c = base_c + FW'(idx) + FW'(1);
		start_c  = hi_hit_c - len_q;
	end

	// update mask and new word contents
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask_c[b] = ((base_c + FW'(b)) >= lo_q) && ((base_c + FW'(b)) < hi_q);
		end
		wdata_c = (act_q == ACT_ALLOC) ? (word_c | mask_c) : (word_c & ~mask_c);
		bit_c   = word_c[lo_q[WBL-1:0]];
	end

	// word range of the update pass
	always_comb begin
		lo_sh_c   = lo_q >> WBL;
		hi_sh_c   = (hi_q - FW'(1)) >> WBL;
		lo_word_c = lo_sh_c[AW-1:0];
		hi_word_c = hi_sh_c[AW-1:0];
	end

	assign issue_c = (cmd.scan_step || cmd.upd_step) && !issued_all_q;
	assign we_c    = cmd.upd_step && rd_pend_q;

	bfa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WC)
	) u_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (pw_q),
		.wdata (wdata_c),
		.re    (issue_c),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// status toward the controller
	always_comb begin
		sts           = '0;
		sts.act       = act_q;
		sts.len_zero  = len_zero_q;
		sts.chk_out   = chk_out_q;
		sts.upd_empty = (lo_q >= hi_q);
		sts.hit       = rd_pend_q && hit_c;
		sts.exhaust   = rd_pend_q && !hit_c && (pw_q == LAST);
		sts.upd_done  = rd_pend_q && (pw_q == end_q);
		sts.out_busy  = out_valid_q && out_stall;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_present_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			frames_present_q <= cfg_wdata;
		end
	end

	// per-word written flags; clearing them marks every frame taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.mark_all) begin
			vld_q <= '0;
		end else if (we_c) begin
			vld_q[pw_q] <= 1'b1;
		end
	end

	// read sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q    <= 1'b0;
			issued_all_q <= 1'b0;
		end else if (cmd.scan_start || cmd.upd_start) begin
			rd_pend_q    <= 1'b0;
			issued_all_q <= 1'b0;
		end else if (cmd.scan_step || cmd.upd_step) begin
			rd_pend_q    <= issue_c;
			issued_all_q <= issued_all_q || (issue_c && addr_q == end_q);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// read address and word pipeline
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			addr_q <= '0;
			end_q  <= LAST;
		end else if (cmd.upd_start) begin
			addr_q <= lo_word_c;
			end_q  <= hi_word_c;
		end else if (issue_c) begin
			addr_q <= addr_q + AW'(1);
			pw_q   <= addr_q;
			vld_s1 <= vld_q[addr_q];
		end
	end

	// request capture, scan carry and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q      <= action;
			len_q      <= FW'(run_length);
			len_zero_q <= (run_length == '0);
			chk_out_q  <= (first_c >= limit_c);
			lo_q       <= first_c;
			hi_q       <= (action == ACT_FREE_ONE) ? first_c + FW'(1) :
				((sum_c > limit_c) ? limit_c : sum_c);
			frame_q    <= '0;
			if (action == ACT_ALLOC && run_length == '0) begin
				status_q <= ST_COUNT_ZERO;
			end else if (action == ACT_FREE_ONE && first_c >= limit_c) begin
				status_q <= ST_ALREADY_FREE;
			end else begin
				status_q <= ST_OK;
			end
		end else if (cmd.scan_start) begin
			carry_q <= '0;
		end else if (cmd.scan_step && rd_pend_q) begin
			carry_q <= run_c[WORD_BITS-1];
			if (hit_c) begin
				lo_q    <= start_c;
				hi_q    <= hi_hit_c;
				frame_q <= start_c[FI_W-1:0];
			end else if (pw_q == LAST) begin
				status_q <= ST_NO_SPACE;
			end
		end else if (we_c && act_q == ACT_FREE_ONE && !bit_c) begin
			status_q <= ST_ALREADY_FREE;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_frame_q  <= frame_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_index_out = out_frame_q;
	assign status          = out_status_q;

`ifndef SYNTHESIS
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we_c |-> (pw_q >= lo_word_c) && (pw_q <= end_q))
		else $error("bitmap write outside the update word range");

	a_load_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over a stalled result");

	a_carry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && rd_pend_q) |-> (carry_q <= limit_c))
		else $error("free run carry exceeds the frame limit");
`endif
endmodule

FILE: rtl/bitmap_frame_allocator_top.sv
// Sequence: allocate scans the bitmap words up to the hit, then marks the words of the run;
// frees clear the words of their range; mark-all and rejected requests go straight to the result.
// Throughput: one request at a time; the one-word-per-cycle bitmap memory port sets the rate.
// Reset: every frame reads as taken at once (per-word written flags clear), frame count 4096.
// A new request is taken while the previous result still waits in the output register.
module bitmap_frame_allocator_top #(
	parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
	parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bfa_pkg::FP_W-1:0]  cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [bfa_pkg::ACT_W-1:0] action,
	input  logic [bfa_pkg::FI_W-1:0]  frame_index,
	input  logic [bfa_pkg::LEN_W-1:0] run_length,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bfa_pkg::FI_W-1:0]  frame_index_out,
	output logic [bfa_pkg::ST_W-1:0]  status
);
	import bfa_pkg::*;

	bfa_cmd_t cmd;
	bfa_sts_t sts;

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfa_datapath #(
		.MAX_FRAMES(MAX_FRAMES),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.action          (action),
		.frame_index     (frame_index),
		.run_length      (run_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_index_out (frame_index_out),
		.status          (status),
		.cmd             (cmd),
		.sts             (sts)
	);
endmodule
